### rtl/hps_pkg.sv
`default_nettype none
package hps_pkg;

	localparam int PID_W         = 7;
	localparam int PRI_W         = 16;
	localparam int FUNC_W        = 3;
	localparam int STATUS_W      = 3;
	localparam int CNT_W         = 7;
	localparam int QUANTUM_W     = 10;
	localparam int MAX_PROCS_DEF = 64;
	localparam int QDEPTH        = 2;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = QUANTUM_W'(10);

	localparam logic [FUNC_W-1:0] FN_CLOCK  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SLEEP  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEPART = 3'd2;
	localparam logic [FUNC_W-1:0] FN_WAKE   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_KILL   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ARRIVE = 3'd5;

	typedef enum logic [2:0] {
		OP_CLOCK,
		OP_SLEEP,
		OP_DEPART,
		OP_WAKE,
		OP_KILL,
		OP_ARRIVE,
		OP_BAD,
		OP_NOP
	} hps_opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_NOT_FOUND   = 3'd1,
		ST_IN_USE      = 3'd2,
		ST_NOT_BLOCKED = 3'd3,
		ST_NO_RUN      = 3'd4,
		ST_BAD_PID     = 3'd5
	} hps_status_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [PID_W-1:0]        proc_id;
		logic signed [PRI_W-1:0] priority_req;
	} hps_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [PID_W-1:0]        run_id;
		logic signed [PRI_W-1:0] run_priority;
		logic [CNT_W-1:0]        ready_count;
		logic [CNT_W-1:0]        blocked_count;
	} hps_rsp_t;

	typedef struct packed {
		hps_opcode_t             op;
		logic [PID_W-1:0]        pid;
		logic signed [PRI_W-1:0] pri;
	} hps_op_t;

endpackage
`default_nettype wire

### rtl/hps_front.sv
`default_nettype none
module hps_front
	import hps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  hps_cmd_t cmd,
	output logic     push,
	output hps_op_t  push_op,
	input  logic     q_full
);

	logic    op_valid_s1;
	hps_op_t op_s1;
	hps_op_t op_cls;
	logic    pid_bad;

	assign pid_bad = (cmd.proc_id == '0) || (int'(cmd.proc_id) > MAX_PROCS);

	always_comb begin
		op_cls.pid = cmd.proc_id;
		op_cls.pri = cmd.priority_req;
		case (cmd.func)
			FN_CLOCK:  op_cls.op = OP_CLOCK;
			FN_SLEEP:  op_cls.op = OP_SLEEP;
			FN_DEPART: op_cls.op = OP_DEPART;
			FN_WAKE:   op_cls.op = pid_bad ? OP_BAD : OP_WAKE;
			FN_KILL:   op_cls.op = pid_bad ? OP_BAD : OP_KILL;
			FN_ARRIVE: op_cls.op = pid_bad ? OP_BAD : OP_ARRIVE;
			default:   op_cls.op = OP_NOP;
		endcase
	end

	assign cmd_stall = op_valid_s1 && q_full;
	assign push      = op_valid_s1 && !q_full;
	assign push_op   = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			op_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1 <= op_cls;
		end
	end

endmodule
`default_nettype wire

### rtl/hps_queue.sv
`default_nettype none
module hps_queue
	import hps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  hps_op_t push_op,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output hps_op_t head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	hps_op_t       slots_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == (PW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

### rtl/hps_back.sv
`default_nettype none
module hps_back
	import hps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  hps_op_t              q_head,
	input  logic [QUANTUM_W-1:0] quantum,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output hps_rsp_t             rsp
);

	localparam int IW         = $clog2(MAX_PROCS + 2);
	localparam int HDEPTH     = MAX_PROCS + 2;
	localparam int TDEPTH     = 2 ** PID_W;
	localparam logic [IW-1:0] HMAX = IW'(MAX_PROCS);
	localparam logic [IW-1:0] ONE  = IW'(1);
	localparam logic HS_READY   = 1'b0;
	localparam logic HS_BLOCKED = 1'b1;

	typedef struct packed {
		logic [PID_W-1:0]        pid;
		logic signed [PRI_W-1:0] pri;
	} ent_t;

	typedef enum logic [1:0] {
		PS_UNUSED  = 2'd0,
		PS_RUNNING = 2'd1,
		PS_BLOCKED = 2'd2,
		PS_READY   = 2'd3
	} pstat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_DISP, S_DEL0, S_DEL1, S_INS, S_UP0, S_UP1,
		S_DN0, S_DN1, S_FIN, S_TK0, S_TK1, S_RUN, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_INS, M_DEL, M_TAKE
	} mode_t;

	function automatic logic signed [PRI_W-1:0] sat17(input logic signed [PRI_W:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7fff;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[PRI_W-1:0];
		end
	endfunction

	// heap and process table storage
	ent_t          rheap [HDEPTH];
	ent_t          bheap [HDEPTH];
	pstat_t        stat_mem [TDEPTH];
	logic [IW-1:0] idx_mem [TDEPTH];
	logic [TDEPTH-1:0] tvalid_q;

	ent_t          rrd0_q, rrd1_q, brd0_q, brd1_q;
	pstat_t        tstat_rd_q;
	logic [IW-1:0] tidx_rd_q;
	logic          tvld_rd_q;

	logic [IW-1:0]    h_ra0, h_ra1, h_wa;
	logic             h_we;
	ent_t             h_wd;
	logic             t_we, t_wst_en;
	logic [PID_W-1:0] t_wa;
	pstat_t           t_wst;
	logic [IW-1:0]    t_widx;

	state_t           state_q;
	hps_op_t          op_q;
	hps_status_t      stat_q;
	logic             del_f_q, ins1_f_q, ins2_f_q, take_f_q;
	logic             del_sel_q, ins1_sel_q, ins1_from_del_q;
	logic [IW-1:0]    del_idx_q;
	logic [PID_W-1:0] ins1_pid_q;
	logic signed [PRI_W-1:0] ins1_pri_q;
	logic signed [PRI_W-1:0] delpri_q;
	pstat_t           ins1_st_q;
	logic             del_ok_q;
	logic             hsel_q;
	ent_t             cur_q;
	logic [IW-1:0]    pos_q;
	mode_t            mode_q;
	logic             moved_q;
	logic             set_st_q;
	pstat_t           st_val_q;
	logic [PID_W-1:0] popped_q;
	ent_t             run_q;
	logic [IW-1:0]    rsize_q, bsize_q;
	logic             rsp_valid_q;
	hps_rsp_t         rsp_q;

	logic [IW-1:0]    n_cur;
	ent_t             rd0, rd1, child;
	logic [IW:0]      two_pos;
	logic             dn_go, use_r, dn_swap, up_brk;
	logic [IW-1:0]    child_pos;
	pstat_t           tst;
	logic [IW-1:0]    tix;
	logic             dec_drop;
	logic             del_in_range;
	logic signed [PRI_W-1:0] clk_pri, slp_pri;
	logic             out_free;

	assign n_cur   = hsel_q ? bsize_q : rsize_q;
	assign rd0     = hsel_q ? brd0_q : rrd0_q;
	assign rd1     = hsel_q ? brd1_q : rrd1_q;
	assign two_pos = {pos_q, 1'b0};
	assign dn_go   = two_pos <= {1'b0, n_cur};
	assign use_r   = (two_pos < {1'b0, n_cur}) && ($signed(rd0.pri) >= $signed(rd1.pri));
	assign child   = use_r ? rd1 : rd0;
	assign child_pos = use_r ? two_pos[IW-1:0] + ONE : two_pos[IW-1:0];
	assign dn_swap = $signed(cur_q.pri) >= $signed(child.pri);
	assign up_brk  = $signed(rd0.pri) < $signed(cur_q.pri);
	assign tst     = tvld_rd_q ? tstat_rd_q : PS_UNUSED;
	assign tix     = tvld_rd_q ? tidx_rd_q : '0;
	assign dec_drop = (run_q.pid != '0) &&
		((op_q.op == OP_DEPART) || ((op_q.op == OP_KILL) && (tst == PS_RUNNING)));
	assign del_in_range = (del_idx_q >= ONE) && (del_idx_q <= n_cur);
	assign clk_pri = sat17($signed({run_q.pri[PRI_W-1], run_q.pri}) +
		$signed({{(PRI_W+1-QUANTUM_W){1'b0}}, quantum}));
	assign slp_pri = sat17($signed({op_q.pri[PRI_W-1], op_q.pri}) +
		$signed({run_q.pri[PRI_W-1], run_q.pri}));
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		h_ra0    = '0;
		h_ra1    = '0;
		h_we     = 1'b0;
		h_wa     = pos_q;
		h_wd     = cur_q;
		t_we     = 1'b0;
		t_wa     = cur_q.pid;
		t_wst_en = 1'b0;
		t_wst    = PS_UNUSED;
		t_widx   = '0;
		case (state_q)
			S_DEC: begin
				if (dec_drop) begin
					t_we     = 1'b1;
					t_wa     = run_q.pid;
					t_wst_en = 1'b1;
				end
			end
			S_DEL0: begin
				h_ra0 = del_idx_q;
				h_ra1 = n_cur;
			end
			S_DEL1: begin
				t_we     = 1'b1;
				t_wa     = op_q.pid;
				t_wst_en = 1'b1;
			end
			S_UP0: h_ra0 = pos_q >> 1;
			S_UP1: begin
				if (!up_brk) begin
					h_we   = 1'b1;
					h_wd   = rd0;
					t_we   = 1'b1;
					t_wa   = rd0.pid;
					t_widx = pos_q;
				end
			end
			S_DN0: begin
				h_ra0 = two_pos[IW-1:0];
				h_ra1 = two_pos[IW-1:0] + ONE;
			end
			S_DN1: begin
				if (dn_swap) begin
					h_we   = 1'b1;
					h_wd   = child;
					t_we   = 1'b1;
					t_wa   = child.pid;
					t_widx = pos_q;
				end
			end
			S_FIN: begin
				h_we     = 1'b1;
				t_we     = 1'b1;
				t_widx   = pos_q;
				t_wst_en = set_st_q;
				t_wst    = st_val_q;
			end
			S_TK0: begin
				h_ra0 = ONE;
				h_ra1 = rsize_q;
			end
			S_RUN: begin
				t_we     = 1'b1;
				t_wa     = popped_q;
				t_wst_en = 1'b1;
				t_wst    = PS_RUNNING;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we && (hsel_q == HS_READY)) begin
			rheap[h_wa] <= h_wd;
		end
		if (h_we && (hsel_q == HS_BLOCKED)) begin
			bheap[h_wa] <= h_wd;
		end
		rrd0_q <= rheap[h_ra0];
		rrd1_q <= rheap[h_ra1];
		brd0_q <= bheap[h_ra0];
		brd1_q <= bheap[h_ra1];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			idx_mem[t_wa] <= t_widx;
			if (t_wst_en) begin
				stat_mem[t_wa] <= t_wst;
			end
		end
		tstat_rd_q <= stat_mem[q_head.pid];
		tidx_rd_q  <= idx_mem[q_head.pid];
	end

	// a pid never written reads as unused with index zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q  <= '0;
			tvld_rd_q <= 1'b0;
		end else begin
			if (t_we) begin
				tvalid_q[t_wa] <= 1'b1;
			end
			tvld_rd_q <= tvalid_q[q_head.pid];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_q            <= '0;
			stat_q          <= ST_OK;
			del_f_q         <= 1'b0;
			ins1_f_q        <= 1'b0;
			ins2_f_q        <= 1'b0;
			take_f_q        <= 1'b0;
			del_sel_q       <= HS_READY;
			ins1_sel_q      <= HS_READY;
			ins1_from_del_q <= 1'b0;
			del_idx_q       <= '0;
			ins1_pid_q      <= '0;
			ins1_pri_q      <= '0;
			delpri_q        <= '0;
			ins1_st_q       <= PS_UNUSED;
			del_ok_q        <= 1'b0;
			hsel_q          <= HS_READY;
			cur_q           <= '0;
			pos_q           <= '0;
			mode_q          <= M_INS;
			moved_q         <= 1'b0;
			set_st_q        <= 1'b0;
			st_val_q        <= PS_UNUSED;
			popped_q        <= '0;
			run_q           <= '0;
			rsize_q         <= '0;
			bsize_q         <= '0;
			rsp_valid_q     <= 1'b0;
			rsp_q           <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q    <= q_head;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					stat_q          <= ST_OK;
					del_f_q         <= 1'b0;
					ins1_f_q        <= 1'b0;
					ins2_f_q        <= 1'b0;
					take_f_q        <= 1'b0;
					ins1_from_del_q <= 1'b0;
					state_q         <= S_DISP;
					case (op_q.op)
						OP_BAD: stat_q <= ST_BAD_PID;
						OP_CLOCK, OP_SLEEP, OP_DEPART: begin
							if (run_q.pid == '0) begin
								stat_q <= ST_NO_RUN;
							end else begin
								take_f_q <= 1'b1;
								ins1_pid_q <= run_q.pid;
								if (op_q.op == OP_CLOCK) begin
									ins1_f_q   <= 1'b1;
									ins1_sel_q <= HS_READY;
									ins1_pri_q <= clk_pri;
									ins1_st_q  <= PS_READY;
								end else if (op_q.op == OP_SLEEP) begin
									ins1_f_q   <= 1'b1;
									ins1_sel_q <= HS_BLOCKED;
									ins1_pri_q <= slp_pri;
									ins1_st_q  <= PS_BLOCKED;
								end
							end
						end
						OP_WAKE: begin
							if (tst != PS_BLOCKED) begin
								stat_q <= ST_NOT_BLOCKED;
							end else begin
								del_f_q         <= 1'b1;
								del_sel_q       <= HS_BLOCKED;
								del_idx_q       <= tix;
								ins1_f_q        <= 1'b1;
								ins1_sel_q      <= HS_READY;
								ins1_pid_q      <= op_q.pid;
								ins1_from_del_q <= 1'b1;
								ins1_st_q       <= PS_READY;
								ins2_f_q        <= (run_q.pid != '0);
								take_f_q        <= 1'b1;
							end
						end
						OP_KILL: begin
							case (tst)
								PS_RUNNING: take_f_q <= 1'b1;
								PS_READY: begin
									del_f_q   <= 1'b1;
									del_sel_q <= HS_READY;
									del_idx_q <= tix;
								end
								PS_BLOCKED: begin
									del_f_q   <= 1'b1;
									del_sel_q <= HS_BLOCKED;
									del_idx_q <= tix;
								end
								default: stat_q <= ST_NOT_FOUND;
							endcase
						end
						OP_ARRIVE: begin
							if (tst != PS_UNUSED) begin
								stat_q <= ST_IN_USE;
							end else begin
								ins1_f_q   <= 1'b1;
								ins1_sel_q <= HS_READY;
								ins1_pid_q <= op_q.pid;
								ins1_pri_q <= op_q.pri;
								ins1_st_q  <= PS_READY;
								ins2_f_q   <= (run_q.pid != '0);
								take_f_q   <= 1'b1;
							end
						end
						default: ;
					endcase
					// departing or killed running process leaves the slot now
					if (dec_drop) begin
						run_q <= '0;
					end
				end
				S_DISP: begin
					if (del_f_q) begin
						hsel_q  <= del_sel_q;
						state_q <= S_DEL0;
					end else if (ins1_f_q) begin
						ins1_f_q  <= 1'b0;
						hsel_q    <= ins1_sel_q;
						cur_q.pid <= ins1_pid_q;
						cur_q.pri <= ins1_from_del_q ? delpri_q : ins1_pri_q;
						st_val_q  <= ins1_st_q;
						state_q   <= S_INS;
					end else if (ins2_f_q) begin
						ins2_f_q <= 1'b0;
						hsel_q   <= HS_READY;
						cur_q    <= run_q;
						st_val_q <= PS_READY;
						state_q  <= S_INS;
					end else if (take_f_q) begin
						take_f_q <= 1'b0;
						hsel_q   <= HS_READY;
						state_q  <= S_TK0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DEL0: begin
					del_f_q  <= 1'b0;
					del_ok_q <= del_in_range;
					if (del_in_range) begin
						if (hsel_q == HS_BLOCKED) begin
							bsize_q <= bsize_q - ONE;
						end else begin
							rsize_q <= rsize_q - ONE;
						end
					end
					state_q <= S_DEL1;
				end
				S_DEL1: begin
					state_q <= S_DISP;
					if (del_ok_q) begin
						delpri_q <= rd0.pri;
						cur_q    <= rd1;
						pos_q    <= del_idx_q;
						if (del_idx_q <= n_cur) begin
							mode_q   <= M_DEL;
							moved_q  <= 1'b0;
							set_st_q <= 1'b0;
							state_q  <= S_UP0;
						end
					end else begin
						delpri_q <= '0;
					end
				end
				S_INS: begin
					if (n_cur >= HMAX) begin
						state_q <= S_DISP;
					end else begin
						if (hsel_q == HS_BLOCKED) begin
							bsize_q <= bsize_q + ONE;
						end else begin
							rsize_q <= rsize_q + ONE;
						end
						pos_q    <= n_cur + ONE;
						mode_q   <= M_INS;
						moved_q  <= 1'b0;
						set_st_q <= 1'b1;
						state_q  <= S_UP0;
					end
				end
				S_UP0: begin
					if (pos_q == ONE) begin
						state_q <= ((mode_q == M_DEL) && !moved_q) ? S_DN0 : S_FIN;
					end else begin
						state_q <= S_UP1;
					end
				end
				S_UP1: begin
					if (up_brk) begin
						state_q <= ((mode_q == M_DEL) && !moved_q) ? S_DN0 : S_FIN;
					end else begin
						pos_q   <= pos_q >> 1;
						moved_q <= 1'b1;
						state_q <= S_UP0;
					end
				end
				S_DN0: begin
					state_q <= dn_go ? S_DN1 : S_FIN;
				end
				S_DN1: begin
					if (dn_swap) begin
						pos_q   <= child_pos;
						state_q <= S_DN0;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= (mode_q == M_TAKE) ? S_RUN : S_DISP;
				end
				S_TK0: begin
					if (rsize_q == '0) begin
						run_q   <= '0;
						state_q <= S_DISP;
					end else begin
						rsize_q <= rsize_q - ONE;
						state_q <= S_TK1;
					end
				end
				S_TK1: begin
					popped_q <= rd0.pid;
					run_q    <= rd0;
					cur_q    <= rd1;
					pos_q    <= ONE;
					mode_q   <= M_TAKE;
					set_st_q <= 1'b0;
					state_q  <= S_DN0;
				end
				S_RUN: begin
					state_q <= S_DISP;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.status        <= stat_q;
						rsp_q.run_id        <= run_q.pid;
						rsp_q.run_priority  <= run_q.pri;
						rsp_q.ready_count   <= CNT_W'(rsize_q);
						rsp_q.blocked_count <= CNT_W'(bsize_q);
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/heap_priority_process_scheduler.sv
// Priority process scheduler with a ready heap and a blocked heap.
// Command channel: cmd_valid / cmd_stall with cmd (func, proc_id,
// priority_req). A command is taken on a rising edge with cmd_valid high
// and cmd_stall low. Response channel: rsp_valid / rsp_stall with rsp
// (status, run_id, run_priority, ready_count, blocked_count), one
// response per command, in command order.
// Configuration: cfg_valid / cfg_ready with cfg_data writes the quantum;
// cfg_ready is always high. Write it only while no command is in flight.
// Commands are registered and classified, then held in a two-entry queue
// in front of the heap sequencer, so new commands keep arriving while a
// response waits on rsp_stall; once the queue fills, cmd_stall rises.
// The heap work is sequenced: every heap pass moves one level at a time
// (registered memory read, then write), and a command does up to four
// passes (delete, two inserts, pop of the minimum). The sequencer takes
// one command at a time.
// Reset empties both heaps, clears the running slot, marks every pid
// unused and sets the quantum to 10; no clearing pass is needed.
`default_nettype none
module heap_priority_process_scheduler
	import hps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  hps_cmd_t             cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output hps_rsp_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [QUANTUM_W-1:0] cfg_data
);

	logic                 push;
	hps_op_t              push_op;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_valid;
	hps_op_t              q_head;
	logic [QUANTUM_W-1:0] quantum_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	hps_front #(.MAX_PROCS(MAX_PROCS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.push_op   (push_op),
		.q_full    (q_full)
	);

	hps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	hps_back #(.MAX_PROCS(MAX_PROCS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.quantum   (quantum_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

### rtl/hps_port_monitor.sv
`default_nettype none
module hps_port_monitor
	import hps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input hps_rsp_t rsp
);

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// an empty running slot always reports priority zero
	a_idle_pri: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.run_id == '0) |-> (rsp.run_priority == '0))
		else $error("nonzero priority with no running process");

	// heaps never hold more than the process limit together
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.ready_count) + int'(rsp.blocked_count) <= MAX_PROCS))
		else $error("heap occupancy above process limit");

endmodule

bind heap_priority_process_scheduler hps_port_monitor #(.MAX_PROCS(MAX_PROCS)) u_port_mon (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
